>>> rtl/core/sha512_pkg.sv
// Shared types, constants and round functions for the SHA-512 hash engine.
package sha512_pkg;

    localparam int Rounds = 80;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD0,
        ST_PADZ,
        ST_PADLO,
        ST_CINIT,
        ST_CROUND,
        ST_CFIN,
        ST_OUT
    } state_t;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] big_s0(input logic [63:0] x);
        big_s0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic logic [63:0] big_s1(input logic [63:0] x);
        big_s1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic logic [63:0] small_s0(input logic [63:0] x);
        small_s0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] small_s1(input logic [63:0] x);
        small_s1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    function automatic logic [63:0] init_hash(input logic [2:0] idx);
        case (idx)
            3'd0: init_hash = 64'h6A09E667F3BCC908;
            3'd1: init_hash = 64'hBB67AE8584CAA73B;
            3'd2: init_hash = 64'h3C6EF372FE94F82B;
            3'd3: init_hash = 64'hA54FF53A5F1D36F1;
            3'd4: init_hash = 64'h510E527FADE682D1;
            3'd5: init_hash = 64'h9B05688C2B3E6C1F;
            3'd6: init_hash = 64'h1F83D9ABFB41BD6B;
            default: init_hash = 64'h5BE0CD19137E2179;
        endcase
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] r);
        case (r)
            7'd0:  round_k = 64'h428A2F98D728AE22;
            7'd1:  round_k = 64'h7137449123EF65CD;
            7'd2:  round_k = 64'hB5C0FBCFEC4D3B2F;
            7'd3:  round_k = 64'hE9B5DBA58189DBBC;
            7'd4:  round_k = 64'h3956C25BF348B538;
            7'd5:  round_k = 64'h59F111F1B605D019;
            7'd6:  round_k = 64'h923F82A4AF194F9B;
            7'd7:  round_k = 64'hAB1C5ED5DA6D8118;
            7'd8:  round_k = 64'hD807AA98A3030242;
            7'd9:  round_k = 64'h12835B0145706FBE;
            7'd10: round_k = 64'h243185BE4EE4B28C;
            7'd11: round_k = 64'h550C7DC3D5FFB4E2;
            7'd12: round_k = 64'h72BE5D74F27B896F;
            7'd13: round_k = 64'h80DEB1FE3B1696B1;
            7'd14: round_k = 64'h9BDC06A725C71235;
            7'd15: round_k = 64'hC19BF174CF692694;
            7'd16: round_k = 64'hE49B69C19EF14AD2;
            7'd17: round_k = 64'hEFBE4786384F25E3;
            7'd18: round_k = 64'h0FC19DC68B8CD5B5;
            7'd19: round_k = 64'h240CA1CC77AC9C65;
            7'd20: round_k = 64'h2DE92C6F592B0275;
            7'd21: round_k = 64'h4A7484AA6EA6E483;
            7'd22: round_k = 64'h5CB0A9DCBD41FBD4;
            7'd23: round_k = 64'h76F988DA831153B5;
            7'd24: round_k = 64'h983E5152EE66DFAB;
            7'd25: round_k = 64'hA831C66D2DB43210;
            7'd26: round_k = 64'hB00327C898FB213F;
            7'd27: round_k = 64'hBF597FC7BEEF0EE4;
            7'd28: round_k = 64'hC6E00BF33DA88FC2;
            7'd29: round_k = 64'hD5A79147930AA725;
            7'd30: round_k = 64'h06CA6351E003826F;
            7'd31: round_k = 64'h142929670A0E6E70;
            7'd32: round_k = 64'h27B70A8546D22FFC;
            7'd33: round_k = 64'h2E1B21385C26C926;
            7'd34: round_k = 64'h4D2C6DFC5AC42AED;
            7'd35: round_k = 64'h53380D139D95B3DF;
            7'd36: round_k = 64'h650A73548BAF63DE;
            7'd37: round_k = 64'h766A0ABB3C77B2A8;
            7'd38: round_k = 64'h81C2C92E47EDAEE6;
            7'd39: round_k = 64'h92722C851482353B;
            7'd40: round_k = 64'hA2BFE8A14CF10364;
            7'd41: round_k = 64'hA81A664BBC423001;
            7'd42: round_k = 64'hC24B8B70D0F89791;
            7'd43: round_k = 64'hC76C51A30654BE30;
            7'd44: round_k = 64'hD192E819D6EF5218;
            7'd45: round_k = 64'hD69906245565A910;
            7'd46: round_k = 64'hF40E35855771202A;
            7'd47: round_k = 64'h106AA07032BBD1B8;
            7'd48: round_k = 64'h19A4C116B8D2D0C8;
            7'd49: round_k = 64'h1E376C085141AB53;
            7'd50: round_k = 64'h2748774CDF8EEB99;
            7'd51: round_k = 64'h34B0BCB5E19B48A8;
            7'd52: round_k = 64'h391C0CB3C5C95A63;
            7'd53: round_k = 64'h4ED8AA4AE3418ACB;
            7'd54: round_k = 64'h5B9CCA4F7763E373;
            7'd55: round_k = 64'h682E6FF3D6B2B8A3;
            7'd56: round_k = 64'h748F82EE5DEFB2FC;
            7'd57: round_k = 64'h78A5636F43172F60;
            7'd58: round_k = 64'h84C87814A1F0AB72;
            7'd59: round_k = 64'h8CC702081A6439EC;
            7'd60: round_k = 64'h90BEFFFA23631E28;
            7'd61: round_k = 64'hA4506CEBDE82BDE9;
            7'd62: round_k = 64'hBEF9A3F7B2C67915;
            7'd63: round_k = 64'hC67178F2E372532B;
            7'd64: round_k = 64'hCA273ECEEA26619C;
            7'd65: round_k = 64'hD186B8C721C0C207;
            7'd66: round_k = 64'hEADA7DD6CDE0EB1E;
            7'd67: round_k = 64'hF57D4F7FEE6ED178;
            7'd68: round_k = 64'h06F067AA72176FBA;
            7'd69: round_k = 64'h0A637DC5A2C898A6;
            7'd70: round_k = 64'h113F9804BEF90DAE;
            7'd71: round_k = 64'h1B710B35131C471B;
            7'd72: round_k = 64'h28DB77F523047D84;
            7'd73: round_k = 64'h32CAAB7B40C72493;
            7'd74: round_k = 64'h3C9EBE0A15C9BEBC;
            7'd75: round_k = 64'h431D67C49C100D4C;
            7'd76: round_k = 64'h4CC5D4BECB3E42B6;
            7'd77: round_k = 64'h597F299CFC657E2A;
            7'd78: round_k = 64'h5FCB6FAB3AD6FAEC;
            7'd79: round_k = 64'h6C44198C4A475817;
            default: round_k = 64'h0;
        endcase
    endfunction

endpackage

>>> rtl/core/sha512_front.sv
// Front end: clamps the byte count and clears bytes past it before queueing.
module sha512_front (
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [63:0]          data_word,
    input  logic [3:0]           byte_count,
    input  logic                 last_word,
    output logic                 q_valid,
    input  logic                 q_stall,
    output sha512_pkg::item_t    q_item
);

    logic [3:0]  count_clamp;
    logic [63:0] keep_mask;

    always_comb
    begin
        count_clamp = (byte_count > 4'd8) ? 4'd8 : byte_count;
        // keep the leading bytes only; a shift of 64 leaves the mask full
        keep_mask = ~({64{1'b1}} >> ({3'b000, count_clamp} * 7'd8));
        q_item.data  = data_word & keep_mask;
        q_item.count = count_clamp;
        q_item.last  = last_word;
    end

    assign q_valid  = in_valid;
    assign in_stall = q_stall;

endmodule

>>> rtl/core/sha512_fifo.sv
// Two-entry queue between the front end and the compression back end.
module sha512_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_stall,
    input  sha512_pkg::item_t    wr_item,
    output logic                 rd_valid,
    input  logic                 rd_stall,
    output sha512_pkg::item_t    rd_item
);

    sha512_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    always_comb
    begin
        do_wr = wr_valid && (cnt_reg != 2'd2);
        do_rd = (cnt_reg != 2'd0) && !rd_stall;
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = entry_reg[rd_ptr_reg];

endmodule

>>> rtl/core/sha512_back.sv
// Back end: byte packing, padding, 80-round compression and digest output.
module sha512_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_stall,
    input  sha512_pkg::item_t    q_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [63:0]          digest_word,
    output logic [2:0]           digest_index,
    output logic                 digest_last
);

    sha512_pkg::state_t state_reg, state_next;
    sha512_pkg::state_t ret_reg, ret_next;

    // schedule window doubles as the block buffer: words shift in at the top
    logic [63:0]  sw_reg [16];
    logic [63:0]  sw_next [16];
    logic [63:0]  hash_reg [8];
    logic [63:0]  hash_next [8];
    logic [63:0]  var_reg [8];
    logic [63:0]  var_next [8];
    logic [63:0]  acc_reg, acc_next;
    logic [2:0]   fill_reg, fill_next;
    logic [4:0]   wc_reg, wc_next;
    logic [6:0]   round_reg, round_next;
    logic [127:0] total_reg, total_next;
    logic         ov_reg, ov_next;
    logic [63:0]  ow_reg, ow_next;
    logic [2:0]   idx_reg, idx_next;

    logic         push_en;
    logic [63:0]  push_word;
    logic [127:0] comb_bytes;
    logic [3:0]   sum_bytes;
    logic [63:0]  w_new, w_t, t1, t2, ch, maj;
    logic [63:0]  hsum [8];
    logic [127:0] bit_len;

    always_comb
    begin
        comb_bytes = {acc_reg, 64'h0} | ({q_item.data, 64'h0} >> ({4'h0, fill_reg} * 7'd8));
        sum_bytes  = {1'b0, fill_reg} + q_item.count;
        bit_len    = {total_reg[124:0], 3'b000};

        w_new = sha512_pkg::small_s1(sw_reg[14]) + sw_reg[9]
              + sha512_pkg::small_s0(sw_reg[1]) + sw_reg[0];
        w_t   = (round_reg < 7'd16) ? sw_reg[0] : w_new;
        ch    = var_reg[6] ^ (var_reg[4] & (var_reg[5] ^ var_reg[6]));
        maj   = (var_reg[0] & var_reg[1]) | (var_reg[2] & (var_reg[0] | var_reg[1]));
        t1    = var_reg[7] + sha512_pkg::big_s1(var_reg[4]) + ch
              + sha512_pkg::round_k(round_reg) + w_t;
        t2    = sha512_pkg::big_s0(var_reg[0]) + maj;
        for (int i = 0; i < 8; i++)
        begin
            hsum[i] = hash_reg[i] + var_reg[i];
        end

        state_next     = state_reg;
        ret_next       = ret_reg;
        acc_next       = acc_reg;
        fill_next      = fill_reg;
        wc_next        = wc_reg;
        round_next     = round_reg;
        total_next     = total_reg;
        ov_next        = ov_reg;
        ow_next        = ow_reg;
        idx_next       = idx_reg;
        push_en        = 1'b0;
        push_word      = 64'h0;
        for (int i = 0; i < 8; i++)
        begin
            hash_next[i] = hash_reg[i];
            var_next[i]  = var_reg[i];
        end
        q_stall = (state_reg != sha512_pkg::ST_IDLE);

        case (state_reg)
            sha512_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    total_next     = total_reg + {124'h0, q_item.count};
                    if (sum_bytes >= 4'd8)
                    begin
                        push_en   = 1'b1;
                        push_word = comb_bytes[127:64];
                        acc_next  = comb_bytes[63:0];
                        fill_next = 3'(sum_bytes - 4'd8);
                    end
                    else
                    begin
                        acc_next  = comb_bytes[127:64];
                        fill_next = sum_bytes[2:0];
                    end
                    if (push_en && (wc_reg == 5'd15))
                    begin
                        state_next = sha512_pkg::ST_CINIT;
                        ret_next   = q_item.last ? sha512_pkg::ST_PAD0 : sha512_pkg::ST_IDLE;
                    end
                    else if (q_item.last)
                    begin
                        state_next = sha512_pkg::ST_PAD0;
                    end
                end
            end
            sha512_pkg::ST_PAD0:
            begin
                push_en   = 1'b1;
                push_word = acc_reg | (64'h80 << ({4'h0, 3'd7 - fill_reg} * 7'd8));
                acc_next  = 64'h0;
                fill_next = 3'd0;
                if (wc_reg == 5'd15)
                begin
                    state_next = sha512_pkg::ST_CINIT;
                    ret_next   = sha512_pkg::ST_PADZ;
                end
                else
                begin
                    state_next = sha512_pkg::ST_PADZ;
                end
            end
            sha512_pkg::ST_PADZ:
            begin
                push_en = 1'b1;
                if (wc_reg == 5'd14)
                begin
                    push_word  = bit_len[127:64];
                    state_next = sha512_pkg::ST_PADLO;
                end
                else if (wc_reg == 5'd15)
                begin
                    state_next = sha512_pkg::ST_CINIT;
                    ret_next   = sha512_pkg::ST_PADZ;
                end
            end
            sha512_pkg::ST_PADLO:
            begin
                push_en    = 1'b1;
                push_word  = bit_len[63:0];
                state_next = sha512_pkg::ST_CINIT;
                ret_next   = sha512_pkg::ST_OUT;
            end
            sha512_pkg::ST_CINIT:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    var_next[i] = hash_reg[i];
                end
                round_next = 7'd0;
                state_next = sha512_pkg::ST_CROUND;
            end
            sha512_pkg::ST_CROUND:
            begin
                var_next[7] = var_reg[6];
                var_next[6] = var_reg[5];
                var_next[5] = var_reg[4];
                var_next[4] = var_reg[3] + t1;
                var_next[3] = var_reg[2];
                var_next[2] = var_reg[1];
                var_next[1] = var_reg[0];
                var_next[0] = t1 + t2;
                if (round_reg == 7'(sha512_pkg::Rounds - 1))
                begin
                    round_next = 7'd0;
                    state_next = sha512_pkg::ST_CFIN;
                end
                else
                begin
                    round_next = round_reg + 7'd1;
                end
            end
            sha512_pkg::ST_CFIN:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hsum[i];
                end
                wc_next    = 5'd0;
                state_next = ret_reg;
                if (ret_reg == sha512_pkg::ST_OUT)
                begin
                    ov_next  = 1'b1;
                    ow_next  = hsum[0];
                    idx_next = 3'd0;
                end
            end
            sha512_pkg::ST_OUT:
            begin
                if (ov_reg && !out_stall)
                begin
                    if (idx_reg == 3'd7)
                    begin
                        // message done: back to the initial hash for the next one
                        ov_next    = 1'b0;
                        total_next = 128'h0;
                        for (int i = 0; i < 8; i++)
                        begin
                            hash_next[i] = sha512_pkg::init_hash(3'(i));
                        end
                        state_next = sha512_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                        ow_next  = hash_reg[idx_reg + 3'd1];
                    end
                end
            end
            default:
            begin
                state_next = sha512_pkg::ST_IDLE;
            end
        endcase

        if (push_en)
        begin
            wc_next = wc_reg + 5'd1;
        end

        for (int i = 0; i < 16; i++)
        begin
            sw_next[i] = sw_reg[i];
        end
        if (push_en || (state_reg == sha512_pkg::ST_CROUND))
        begin
            for (int i = 0; i < 15; i++)
            begin
                sw_next[i] = sw_reg[i + 1];
            end
            sw_next[15] = push_en ? push_word : w_t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha512_pkg::ST_IDLE;
            ret_reg       <= sha512_pkg::ST_IDLE;
            fill_reg      <= 3'd0;
            acc_reg       <= 64'h0;
            wc_reg        <= 5'd0;
            round_reg     <= 7'd0;
            total_reg     <= 128'h0;
            ov_reg        <= 1'b0;
            idx_reg       <= 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= sha512_pkg::init_hash(3'(i));
            end
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            fill_reg      <= fill_next;
            acc_reg       <= acc_next;
            wc_reg        <= wc_next;
            round_reg     <= round_next;
            total_reg     <= total_next;
            ov_reg        <= ov_next;
            idx_reg       <= idx_next;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= hash_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ow_reg <= ow_next;
        for (int i = 0; i < 8; i++)
        begin
            var_reg[i] <= var_next[i];
        end
        for (int i = 0; i < 16; i++)
        begin
            sw_reg[i] <= sw_next[i];
        end
    end

    assign out_valid    = ov_reg;
    assign digest_word  = ow_reg;
    assign digest_index = idx_reg;
    assign digest_last  = (idx_reg == 3'd7);

`ifndef SYNTHESIS
    a_wc_range: assert property (@(posedge clk) disable iff (!rst_n)
        wc_reg <= 5'd16)
        else $error("block word count out of range");
    a_idle_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha512_pkg::ST_IDLE) |-> (wc_reg < 5'd16))
        else $error("idle with a full block");
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (state_reg == sha512_pkg::ST_OUT))
        else $error("digest shown outside output phase");
    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha512_pkg::ST_CFIN) |-> $past(round_reg) == 7'(sha512_pkg::Rounds - 1))
        else $error("compression ended early");
`endif

endmodule

>>> rtl/core/sha512_hash_engine_core.sv
// Top level of the SHA-512 hash engine: front end, queue and compression back end.
// Each block takes 16 word pushes, then a load, 80 rounds and a hash update.
// A word is taken while the back end is idle; a full block stalls it during compression,
// and intake stalls once the two-entry queue has filled behind it.
// The final word adds 3 to 18 padding pushes and one or two compressions, then
// eight digest transactions, one per cycle when the output is not stalled.
// Reset (rst_n low, asynchronous) empties the queue and restores the initial hash.
module sha512_hash_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data_word,
    input  logic [3:0]  byte_count,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic [2:0]  digest_index,
    output logic        digest_last
);

    sha512_pkg::item_t fq_item, qb_item;
    logic fq_valid, fq_stall, qb_valid, qb_stall;

    sha512_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last_word  (last_word),
        .q_valid    (fq_valid),
        .q_stall    (fq_stall),
        .q_item     (fq_item)
    );

    sha512_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_stall (fq_stall),
        .wr_item  (fq_item),
        .rd_valid (qb_valid),
        .rd_stall (qb_stall),
        .rd_item  (qb_item)
    );

    sha512_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (qb_valid),
        .q_stall      (qb_stall),
        .q_item       (qb_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digest_word  (digest_word),
        .digest_index (digest_index),
        .digest_last  (digest_last)
    );

endmodule

>>> tb/sha512_hash_engine_core_tb.sv
// Self-checking testbench for the SHA-512 hash engine core.
module sha512_hash_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last_word;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;

    typedef struct {
        logic [63:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_t;

    sha512_hash_engine_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_word(data_word),
        .byte_count(byte_count),
        .last_word(last_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .digest_word(digest_word),
        .digest_index(digest_index),
        .digest_last(digest_last)
    );

    // Predictor state
    logic [63:0]  k_tab [80];
    logic [63:0]  h_iv [8];
    logic [63:0]  chain [8];
    logic [63:0]  blk [16];
    logic [127:0] msg_bytes;
    digest_t      digest_q [$];

    int  errors;
    int  digests_seen;
    int  messages_sent;
    bit  gaps_on;
    bit  hold_rx;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [63:0] ror64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic hash_block();
        logic [63:0] w [16];
        logic [63:0] v [8];
        logic [63:0] a, b, wr, t1, t2;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 16)
                wr = w[r];
            else
            begin
                a = w[(r - 2) & 15];
                b = w[(r - 15) & 15];
                wr = (ror64(a, 19) ^ ror64(a, 61) ^ (a >> 6)) + w[(r - 7) & 15]
                   + (ror64(b, 1) ^ ror64(b, 8) ^ (b >> 7)) + w[r & 15];
                w[r & 15] = wr;
            end
            t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
               + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + k_tab[r] + wr;
            t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
               + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] += v[i];
        for (int i = 0; i < 16; i++) blk[i] = '0;
    endtask

    task automatic place_byte(int pos, logic [7:0] val);
        blk[(pos >> 3) & 15][(7 - (pos & 7)) * 8 +: 8] = val;
    endtask

    task automatic restart_message();
        for (int i = 0; i < 8; i++) chain[i] = h_iv[i];
        for (int i = 0; i < 16; i++) blk[i] = '0;
        msg_bytes = '0;
    endtask

    task automatic predict_word(logic [63:0] d, logic [3:0] cnt, logic lst);
        int n;
        int pos;
        logic [127:0] bits;
        digest_t e;
        n = (cnt > 8) ? 8 : cnt;
        for (int i = 0; i < n; i++)
        begin
            pos = msg_bytes[6:0];
            place_byte(pos, d[56 - 8 * i +: 8]);
            msg_bytes = msg_bytes + 1;
            if (pos == 127) hash_block();
        end
        if (!lst) return;
        bits = msg_bytes << 3;
        pos = msg_bytes[6:0];
        place_byte(pos, 8'h80);
        if (pos + 1 > 112) hash_block();
        blk[14] = bits[127:64];
        blk[15] = bits[63:0];
        hash_block();
        for (int i = 0; i < 8; i++)
        begin
            e.word = chain[i];
            e.index = i[2:0];
            e.last = (i == 7);
            digest_q.push_back(e);
        end
        restart_message();
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
    endtask

    // Send one transaction; the predictor sees it as it is accepted.
    // Valid stays high after acceptance until a gap or the next payload replaces it.
    task automatic send_word(logic [63:0] d, logic [3:0] cnt, logic lst);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_word  <= d;
        byte_count <= cnt;
        last_word  <= lst;
        do @(posedge clk); while (in_stall);
        predict_word(d, cnt, lst);
        if (lst) messages_sent++;
        @(negedge clk);
    endtask

    // Random message: mostly full words, short words anywhere.
    task automatic send_message(int nwords);
        logic [3:0] c;
        for (int i = 0; i < nwords; i++)
        begin
            c = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
            send_word({$urandom, $urandom}, c, i == nwords - 1);
        end
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (digest_q.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        digest_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            digests_seen++;
            if (digest_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected digest transaction", $realtime);
            end
            else
            begin
                e = digest_q.pop_front();
                if (digest_word !== e.word)
                    report_mismatch("digest_word", digest_word, e.word);
                if (digest_index !== e.index)
                    report_mismatch("digest_index", 64'(digest_index), 64'(e.index));
                if (digest_last !== e.last)
                    report_mismatch("digest_last", 64'(digest_last), 64'(e.last));
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_rx)
            out_stall <= 1'b1;
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(negedge clk);
            out_stall <= 1'b0;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic test_known_vectors();
        // Empty message, then "abc"
        send_word(64'h0, 4'd0, 1'b1);
        send_word(64'h6162630000000000, 4'd3, 1'b1);
    endtask

    task automatic test_edges();
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
        send_word(64'h0, 4'd9, 1'b0);
        send_word(64'hA5A5_5A5A_0F0F_F0F0, 4'd5, 1'b0);
        send_word(64'h5555_AAAA_3333_CCCC, 4'd1, 1'b0);
        send_word(64'h0123_4567_89AB_CDEF, 4'd7, 1'b1);
        // 111 bytes: padding fits; 112 bytes: needs a second block
        for (int i = 0; i < 13; i++) send_word({$urandom, $urandom}, 4'd8, 1'b0);
        send_word({$urandom, $urandom}, 4'd7, 1'b1);
        for (int i = 0; i < 14; i++) send_word({$urandom, $urandom}, 4'd8, 1'b0);
        send_word({$urandom, $urandom}, 4'd0, 1'b1);
        // exactly one full block, empty final word
        for (int i = 0; i < 16; i++) send_word({$urandom, $urandom}, 4'd8, 1'b0);
        send_word(64'hDEAD_BEEF_0000_0000, 4'd0, 1'b1);
    endtask

    // Hold the receiver off for a counted stretch while messages keep coming.
    task automatic test_backpressure();
        fork
            begin
                hold_rx = 1'b1;
                repeat (400) @(posedge clk);
                hold_rx = 1'b0;
            end
            begin
                for (int m = 0; m < 3; m++) send_message(3);
                send_message(2);
            end
        join
    endtask

    task automatic test_random_messages();
        int sent;
        sent = 0;
        while (sent < 40)
        begin
            int n;
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 34) : $urandom_range(1, 6);
            send_message(n);
            sent += n;
        end
    endtask

    initial
    begin
        errors = 0;
        digests_seen = 0;
        messages_sent = 0;
        gaps_on = 1'b0;
        hold_rx = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_word = '0;
        byte_count = '0;
        last_word = 1'b0;
        out_stall = 1'b0;
        for (int i = 0; i < 80; i++) k_tab[i] = sha512_pkg::round_k(i[6:0]);
        for (int i = 0; i < 8; i++) h_iv[i] = sha512_pkg::init_hash(i[2:0]);
        restart_message();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_known_vectors();
        test_edges();
        gaps_on = 1'b1;
        test_backpressure();
        test_random_messages();
        gaps_on = 1'b0;
        for (int m = 0; m < 2; m++) send_message($urandom_range(1, 8));
        in_valid <= 1'b0;
        wait_drained();

        $display("Hashed %0d messages of varied lengths and padding cases,", messages_sent);
        $display("with a long receiver hold; %0d digest words checked.", digests_seen);
        if (errors == 0 && digest_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
